/* sv/uwbtri_pkg.sv */
// shared types and constants for the three range trilateration block
package uwbtri_pkg;

    localparam int LEN_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 18;
    localparam int Z_W       = 16;
    localparam int FB_W      = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAG_HEIGHT      = 3'd0,
        CFG_ANCHOR_TWO_X    = 3'd1,
        CFG_ANCHOR_TWO_Y    = 3'd2,
        CFG_BASELINE_LENGTH = 3'd3,
        CFG_SIDE_LENGTH_ONE = 3'd4,
        CFG_SIDE_LENGTH_TWO = 3'd5,
        CFG_REF_COSINE_ONE  = 3'd6,
        CFG_REF_COSINE_TWO  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] tag_height;
        logic signed [CFG_W-1:0] anchor_two_x;
        logic signed [CFG_W-1:0] anchor_two_y;
        logic        [LEN_W-1:0] baseline_length;
        logic        [LEN_W-1:0] side_length_one;
        logic        [LEN_W-1:0] side_length_two;
        logic signed [CFG_W-1:0] ref_cosine_one;
        logic signed [CFG_W-1:0] ref_cosine_two;
    } cfg_t;

endpackage

/* sv/uwb_three_range_trilateration.sv */
// three anchor cosine rule trilateration top level
// the input stalls while an item is in work, so a new item is taken only once the last
// result is registered on the output; a cosine that falls back skips the divide steps
// the work runs on the shared multiplier and the one bit per cycle divide and root steps
// reset: registers to their listed values, last cosine to one, first flag set
module uwb_three_range_trilateration
#(
    parameter int RANGE_BITS    = 16,
    parameter int COS_FRAC_BITS = 14
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [uwbtri_pkg::LEN_W-1:0]            range_zero,
    input  logic [uwbtri_pkg::LEN_W-1:0]            range_one,
    input  logic [uwbtri_pkg::LEN_W-1:0]            range_two,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [uwbtri_pkg::POS_W-1:0]     pos_x,
    output logic signed [uwbtri_pkg::POS_W-1:0]     pos_y,
    output logic signed [uwbtri_pkg::Z_W-1:0]       pos_z,
    output logic                                    rear_flag,
    output logic                                    initial_flag,
    output logic [uwbtri_pkg::FB_W-1:0]             fallback_mask,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [uwbtri_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [uwbtri_pkg::CFG_W-1:0]            cfg_data
);

    localparam int F    = COS_FRAC_BITS;
    localparam int LW   = uwbtri_pkg::LEN_W;
    localparam int RW   = (RANGE_BITS < LW) ? RANGE_BITS : LW;
    localparam int CW   = F + 2;
    localparam int QW   = F + 1;
    localparam int MW   = (QW > LW) ? QW : LW;
    localparam int PW   = 2 * MW;
    localparam int DW   = 2 * LW + 1;
    localparam int NW   = DW + F + 1;
    localparam int SQW  = F + 4;
    localparam int VW   = 2 * F + 2;
    localparam int SUBW = (DW + 1 > SQW) ? DW + 1 : SQW;
    localparam int CNTW = $clog2(QW);
    localparam int PP   = F + 18;
    localparam int YW   = 20;
    localparam int RCW  = (CW > uwbtri_pkg::CFG_W) ? CW : uwbtri_pkg::CFG_W;
    localparam int POSW = uwbtri_pkg::POS_W;

    localparam logic signed [CW-1:0] COS_ONE = {2'b01, {F{1'b0}}};
    localparam logic signed [YW-1:0] POS_MAX = YW'((2 ** (POSW - 1)) - 1);
    localparam logic signed [YW-1:0] POS_MIN = -YW'(2 ** (POSW - 1));

    typedef enum logic [4:0] {
        S_IDLE, S_E0, S_E1, S_E2, S_E3, S_E4, S_DIV, S_DEND, S_EEND,
        S_Y0, S_Y1, S_X0, S_X1, S_SQ, S_X2, S_X3, S_DONE
    } state_t;

    uwbtri_pkg::cfg_t cfg;

    state_t                      state_reg;
    logic [RW-1:0]               r0_reg, r1_reg, r2_reg;
    logic [LW-1:0]               opa_reg, opb_reg, opc_reg;
    logic [DW-1:0]               acc_reg, mag_reg, den_reg, rem_reg;
    logic                        neg_reg;
    logic [QW-1:0]               nlo_reg, q_reg;
    logic [CNTW-1:0]             cnt_reg;
    logic signed [CW-1:0]        cos_reg, c1_reg, last_reg;
    logic                        fell_reg, c1_ok_reg, side_reg, rear_reg, first_reg;
    logic signed [uwbtri_pkg::CFG_W-1:0] ref_reg;
    logic [uwbtri_pkg::FB_W-1:0] fb_reg;
    logic signed [YW-1:0]        y_reg;
    logic signed [POSW-1:0]      x_reg;
    logic [SQW-1:0]              sqr_reg;
    logic [VW-1:0]               v_reg;
    logic                        out_valid_reg, rear_out_reg, init_out_reg;
    logic signed [POSW-1:0]      pos_x_reg, pos_y_reg;
    logic signed [uwbtri_pkg::Z_W-1:0] pos_z_reg;
    logic [uwbtri_pkg::FB_W-1:0] fb_out_reg;

    logic [MW-1:0]               mul_a, mul_b;
    logic [PW-1:0]               prod;
    logic [SUBW-1:0]             sub_a, sub_b;
    logic [SUBW:0]               sub_d;
    logic                        sub_ge;
    logic [DW:0]                 diff;
    logic [DW-1:0]               den_calc;
    logic [NW-1:0]               numer;
    logic                        cos_fell;
    logic [DW:0]                 div_t;
    logic [SQW-1:0]              sq_rs;
    logic [QW-1:0]               c1_mag, cos_mag;
    logic [PP-1:0]               rnd;
    logic [POSW-1:0]             pmag;
    logic signed [YW-1:0]        psc, y_calc, x_calc;
    logic signed [CW-1:0]        q_signed, c3_val;

    function automatic logic signed [POSW-1:0] sat_pos(input logic signed [YW-1:0] v);
        logic signed [YW-1:0] r;
        r = v;
        if (v > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN;
        end
        return r[POSW-1:0];
    endfunction

    uwbtri_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uwbtri_mul #(.W(MW)) u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // magnitudes for the multiplier
    assign c1_mag  = c1_reg[CW-1] ? QW'(-c1_reg) : QW'(c1_reg);
    assign cos_mag = cos_reg[CW-1] ? QW'(-cos_reg) : QW'(cos_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_E0:
            begin
                mul_a = MW'(opb_reg);
                mul_b = MW'(opb_reg);
            end
            S_E1:
            begin
                mul_a = MW'(opc_reg);
                mul_b = MW'(opc_reg);
            end
            S_E2:
            begin
                mul_a = MW'(opa_reg);
                mul_b = MW'(opa_reg);
            end
            S_E3:
            begin
                mul_a = MW'(opb_reg);
                mul_b = MW'(opc_reg);
            end
            S_Y0:
            begin
                mul_a = MW'(r2_reg);
                mul_b = MW'(c1_mag);
            end
            S_X0:
            begin
                mul_a = MW'(cos_mag);
                mul_b = MW'(cos_mag);
            end
            S_X2:
            begin
                mul_a = MW'(r2_reg);
                mul_b = MW'(q_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared compare and subtract for divide and root steps
    assign div_t = {rem_reg, nlo_reg[QW-1]};
    assign sq_rs = {sqr_reg[SQW-3:0], v_reg[VW-1:VW-2]};

    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            sub_a = SUBW'(sq_rs);
            sub_b = SUBW'({q_reg, 2'b01});
        end
        else
        begin
            sub_a = SUBW'(div_t);
            sub_b = SUBW'(den_reg);
        end
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[SUBW];

    // cosine set-up arithmetic
    assign diff     = {1'b0, acc_reg} - {1'b0, DW'(prod)};
    assign den_calc = {prod[DW-2:0], 1'b0};
    assign numer    = (NW'(mag_reg) << F) + NW'(prod[DW-2:0]);
    assign cos_fell = (prod[DW-2:0] == '0) || (mag_reg > den_calc);
    assign q_signed = neg_reg ? -CW'(q_reg) : CW'(q_reg);
    assign c3_val   = c1_ok_reg ? c1_reg : last_reg;

    // round a range times cosine or sine product to whole mm
    assign rnd    = PP'(prod) + (PP'(1) << (F - 1));
    assign pmag   = rnd[F+POSW-1:F];
    assign psc    = signed'(YW'(pmag));
    assign y_calc = YW'(cfg.anchor_two_y) + (c1_reg[CW-1] ? -psc : psc);
    assign x_calc = YW'(cfg.anchor_two_x) + (rear_reg ? -psc : psc);

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign rear_flag     = rear_out_reg;
    assign initial_flag  = init_out_reg;
    assign fallback_mask = fb_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r0_reg        <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            opa_reg       <= '0;
            opb_reg       <= '0;
            opc_reg       <= '0;
            acc_reg       <= '0;
            mag_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            nlo_reg       <= '0;
            q_reg         <= '0;
            cnt_reg       <= '0;
            cos_reg       <= '0;
            c1_reg        <= '0;
            last_reg      <= COS_ONE;
            fell_reg      <= 1'b0;
            c1_ok_reg     <= 1'b0;
            side_reg      <= 1'b0;
            rear_reg      <= 1'b0;
            first_reg     <= 1'b1;
            ref_reg       <= '0;
            fb_reg        <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            sqr_reg       <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            rear_out_reg  <= 1'b0;
            init_out_reg  <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            fb_out_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        r0_reg    <= range_zero[RW-1:0];
                        r1_reg    <= range_one[RW-1:0];
                        r2_reg    <= range_two[RW-1:0];
                        opa_reg   <= LW'(range_one[RW-1:0]);
                        opb_reg   <= LW'(range_two[RW-1:0]);
                        opc_reg   <= cfg.baseline_length;
                        side_reg  <= 1'b0;
                        fb_reg    <= '0;
                        state_reg <= S_E0;
                    end
                end
                S_E0:
                begin
                    state_reg <= S_E1;
                end
                S_E1:
                begin
                    acc_reg   <= DW'(prod);
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    acc_reg   <= acc_reg + DW'(prod);
                    state_reg <= S_E3;
                end
                S_E3:
                begin
                    neg_reg   <= diff[DW];
                    mag_reg   <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
                    state_reg <= S_E4;
                end
                S_E4:
                begin
                    den_reg <= den_calc;
                    rem_reg <= numer[NW-1:F+1];
                    nlo_reg <= numer[F:0];
                    q_reg   <= '0;
                    cnt_reg <= '0;
                    if (cos_fell)
                    begin
                        cos_reg   <= last_reg;
                        fell_reg  <= 1'b1;
                        state_reg <= S_EEND;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= sub_ge ? sub_d[DW-1:0] : div_t[DW-1:0];
                    nlo_reg <= {nlo_reg[QW-2:0], 1'b0};
                    q_reg   <= {q_reg[QW-2:0], sub_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(QW - 1))
                    begin
                        state_reg <= S_DEND;
                    end
                end
                S_DEND:
                begin
                    cos_reg   <= q_signed;
                    last_reg  <= q_signed;
                    fell_reg  <= 1'b0;
                    state_reg <= S_EEND;
                end
                S_EEND:
                begin
                    if (!side_reg)
                    begin
                        c1_reg    <= cos_reg;
                        c1_ok_reg <= !fell_reg;
                        fb_reg[0] <= fell_reg;
                        state_reg <= S_Y0;
                    end
                    else
                    begin
                        fb_reg[1] <= fell_reg;
                        fb_reg[2] <= !c1_ok_reg;
                        rear_reg  <= (RCW'(cos_reg) > RCW'(ref_reg));
                        // third cosine reuses the first, or the last stored one if the first fell back
                        cos_reg   <= c3_val;
                        last_reg  <= c3_val;
                        state_reg <= S_X0;
                    end
                end
                S_Y0:
                begin
                    state_reg <= S_Y1;
                end
                S_Y1:
                begin
                    y_reg    <= y_calc;
                    opa_reg  <= LW'(r0_reg);
                    side_reg <= 1'b1;
                    if (y_calc <= 0)
                    begin
                        opb_reg <= LW'(r1_reg);
                        opc_reg <= cfg.side_length_one;
                        ref_reg <= cfg.ref_cosine_one;
                    end
                    else
                    begin
                        opb_reg <= LW'(r2_reg);
                        opc_reg <= cfg.side_length_two;
                        ref_reg <= cfg.ref_cosine_two;
                    end
                    state_reg <= S_E0;
                end
                S_X0:
                begin
                    state_reg <= S_X1;
                end
                S_X1:
                begin
                    v_reg     <= (VW'(1) << (2 * F)) - prod[VW-1:0];
                    sqr_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sqr_reg <= sub_ge ? sub_d[SQW-1:0] : sq_rs;
                    q_reg   <= {q_reg[QW-2:0], sub_ge};
                    v_reg   <= {v_reg[VW-3:0], 2'b00};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(QW - 1))
                    begin
                        state_reg <= S_X2;
                    end
                end
                S_X2:
                begin
                    state_reg <= S_X3;
                end
                S_X3:
                begin
                    x_reg     <= sat_pos(x_calc);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_x_reg     <= x_reg;
                        pos_y_reg     <= sat_pos(y_reg);
                        pos_z_reg     <= cfg.tag_height;
                        rear_out_reg  <= rear_reg;
                        init_out_reg  <= first_reg;
                        fb_out_reg    <= fb_reg;
                        first_reg     <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // stored cosine never leaves the unit interval
    a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg <= COS_ONE) && (last_reg >= -COS_ONE))
        else $error("stored cosine out of range");

    // a transaction on the input starts work that holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after transaction");

    // a finished divide gives a quotient no larger than one
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEND) |-> (q_reg <= QW'(COS_ONE)))
        else $error("cosine quotient above one");

    // sine from the root never exceeds one
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_X2) |-> (q_reg <= QW'(COS_ONE)))
        else $error("sine above one");

    // the side evaluation only starts after y is known
    a_side_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Y1) |=> (state_reg == S_E0) && side_reg)
        else $error("side evaluation out of order");
`endif

endmodule

/* sv/uwbtri_cfg.sv */
// configuration register file
module uwbtri_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uwbtri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uwbtri_pkg::CFG_W-1:0]        cfg_data,
    output uwbtri_pkg::cfg_t                    cfg
);

    uwbtri_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                 <= '0;
            cfg_reg.baseline_length <= uwbtri_pkg::LEN_RESET;
            cfg_reg.side_length_one <= uwbtri_pkg::LEN_RESET;
            cfg_reg.side_length_two <= uwbtri_pkg::LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (uwbtri_pkg::cfg_idx_t'(cfg_index))
                uwbtri_pkg::CFG_TAG_HEIGHT:      cfg_reg.tag_height      <= cfg_data;
                uwbtri_pkg::CFG_ANCHOR_TWO_X:    cfg_reg.anchor_two_x    <= cfg_data;
                uwbtri_pkg::CFG_ANCHOR_TWO_Y:    cfg_reg.anchor_two_y    <= cfg_data;
                uwbtri_pkg::CFG_BASELINE_LENGTH: cfg_reg.baseline_length <= cfg_data;
                uwbtri_pkg::CFG_SIDE_LENGTH_ONE: cfg_reg.side_length_one <= cfg_data;
                uwbtri_pkg::CFG_SIDE_LENGTH_TWO: cfg_reg.side_length_two <= cfg_data;
                uwbtri_pkg::CFG_REF_COSINE_ONE:  cfg_reg.ref_cosine_one  <= cfg_data;
                uwbtri_pkg::CFG_REF_COSINE_TWO:  cfg_reg.ref_cosine_two  <= cfg_data;
                default:                         cfg_reg.tag_height      <= cfg_reg.tag_height;
            endcase
        end
    end

endmodule

/* sv/uwbtri_mul.sv */
// shared unsigned multiplier with registered product
module uwbtri_mul
#(
    parameter int W = 16
)
(
    input  logic           clk,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    assign p = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule
